[rtl/qpr_pkg.sv]
// ----------------------------------------------------------------------------
// qpr_pkg
// Types, constants and the arctangent table for the quadratic phase rotator.
// ----------------------------------------------------------------------------
`default_nettype none
package qpr_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int PHASE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int NUM_CELLS     = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  localparam int GAIN_FRAC = 20;
  localparam int GAIN_COMP = 636751;
  localparam int GAIN_BITS = 21;

  localparam int XW = SAMPLE_BITS + GAIN_FRAC + 3;
  localparam int ZW = 34;

  localparam int CFG_AW = 2;

  typedef enum logic [CFG_AW-1:0] {
    REG_PHASE_SLOPE   = 2'd0,
    REG_POSITION_STEP = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic                 vld;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  function automatic logic [31:0] atan_turns(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/qpr_phase.sv]
// ----------------------------------------------------------------------------
// qpr_phase
// Position tracking, quadratic phase word, gain scaling and quadrant fold.
// ----------------------------------------------------------------------------
`default_nettype none
module qpr_phase
  import qpr_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          adv,
  input  wire logic                          in_acc,
  input  wire logic signed [SAMPLE_BITS-1:0] in_re,
  input  wire logic signed [SAMPLE_BITS-1:0] in_im,
  input  wire logic                          record_start,
  input  wire logic [31:0]                   start_position,
  input  wire logic [31:0]                   phase_slope,
  input  wire logic [31:0]                   position_step,
  output cordic_t                            cell_o
);

  localparam int PW = SAMPLE_BITS + GAIN_BITS + 1;

  logic [31:0]          position_r;
  logic [31:0]          t;
  logic                 v1_r, v2_r, v3_r;
  logic [63:0]          sq_r;
  logic [63:0]          lo_r;
  logic [31:0]          sqhi_r;
  logic [PHASE_BITS-1:0] p_r;
  logic signed [XW-1:0] x1_r, y1_r, x2_r, y2_r, x3_r, y3_r;
  logic signed [PW-1:0] xg, yg;
  logic signed [65:0]   lo_full;
  logic [31:0]          hi_prod;
  logic [31:0]          top32;
  logic [31:0]          zu;
  logic signed [31:0]   zs;
  cordic_t              cell_r;
  cordic_t              cell_nxt;

  assign t  = record_start ? start_position : position_r;
  assign xg = in_re * $signed(GAIN_BITS'(GAIN_COMP));
  assign yg = in_im * $signed(GAIN_BITS'(GAIN_COMP));

  assign lo_full = $signed(phase_slope) * $signed({1'b0, sq_r[31:0]});
  assign hi_prod = phase_slope * sqhi_r;
  assign top32   = lo_r[63:32] + hi_prod;

  assign zu = 32'd0 - {p_r, {(32-PHASE_BITS){1'b0}}};
  assign zs = $signed(zu);

  always_comb begin
    cell_nxt.vld = v3_r;
    cell_nxt.x   = x3_r;
    cell_nxt.y   = y3_r;
    cell_nxt.z   = ZW'(zs);
    if (zs > 32'sd1073741824) begin
      cell_nxt.x = -x3_r;
      cell_nxt.y = -y3_r;
      cell_nxt.z = ZW'(zs) - ZW'(64'sd2147483648);
    end else if (zs < -32'sd1073741824) begin
      cell_nxt.x = -x3_r;
      cell_nxt.y = -y3_r;
      cell_nxt.z = ZW'(zs) + ZW'(64'sd2147483648);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      cell_r.vld <= 1'b0;
    end else if (adv) begin
      if (in_acc) position_r <= t + position_step;
      v1_r       <= in_acc;
      v2_r       <= v1_r;
      v3_r       <= v2_r;
      cell_r.vld <= cell_nxt.vld;
      cell_r.x   <= cell_nxt.x;
      cell_r.y   <= cell_nxt.y;
      cell_r.z   <= cell_nxt.z;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r   <= t * t;
      x1_r   <= XW'(xg);
      y1_r   <= XW'(yg);
      lo_r   <= lo_full[63:0];
      sqhi_r <= sq_r[63:32];
      x2_r   <= x1_r;
      y2_r   <= y1_r;
      p_r    <= top32[31:32-PHASE_BITS];
      x3_r   <= x2_r;
      y3_r   <= y2_r;
    end
  end

  assign cell_o = cell_r;

endmodule
`default_nettype wire

[rtl/qpr_cell.sv]
// ----------------------------------------------------------------------------
// qpr_cell
// One CORDIC rotation cell; its index sets the shift and the angle step.
// ----------------------------------------------------------------------------
`default_nettype none
module qpr_cell
  import qpr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       adv,
  input  wire logic [4:0] idx,
  input  cordic_t         cell_i,
  output cordic_t         cell_o
);

  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] da;
  cordic_t              cell_r;

  assign dx = cell_i.y >>> idx;
  assign dy = cell_i.x >>> idx;
  assign da = $signed({{(ZW-32){1'b0}}, atan_turns(idx)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (adv) begin
      cell_r.vld <= cell_i.vld;
      if (!cell_i.z[ZW-1]) begin
        cell_r.x <= cell_i.x - dx;
        cell_r.y <= cell_i.y + dy;
        cell_r.z <= cell_i.z - da;
      end else begin
        cell_r.x <= cell_i.x + dx;
        cell_r.y <= cell_i.y - dy;
        cell_r.z <= cell_i.z + da;
      end
    end
  end

  assign cell_o = cell_r;

endmodule
`default_nettype wire

[rtl/quadratic_phase_rotator_top.sv]
// ----------------------------------------------------------------------------
// quadratic_phase_rotator_top
// Dechirp mixer: rotates I/Q samples by minus a quadratic phase q*t^2.
// ----------------------------------------------------------------------------
// in_*  : sample requests; tdata = re, im, start_position; tuser = record_start.
// out_* : rotated requests; tdata = re, im, rounded and saturated.
// cfg_* : register writes, index 0 = phase_slope, 1 = position_step; always
//         ready, to be written while the block is idle.
// Pipeline: four phase/scaling stages, one stage per CORDIC cell (16) and an
// output register. One sample is taken per cycle unless the output is stalled.
// When the receiver stalls with a result held, the whole chain freezes and
// in_tready drops in the same cycle; no result is lost.
// Reset clears the pipeline valid bits, position (0), phase_slope (0) and
// position_step (1).
// ----------------------------------------------------------------------------
`default_nettype none
module quadratic_phase_rotator_top
  import qpr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output      logic              in_tready,
  input  wire logic [63:0]       in_tdata,   // re[15:0], im[31:16], start_position[63:32]
  input  wire logic [0:0]        in_tuser,   // record_start[0]
  output      logic              out_tvalid,
  input  wire logic              out_tready,
  output      logic [31:0]       out_tdata,  // re[15:0], im[31:16]
  input  wire logic              cfg_valid,
  output      logic              cfg_ready,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [31:0]       cfg_data
);

  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [31:0] phase_slope_r, position_step_r;
  logic        adv, in_acc;
  logic        out_vld_r;
  logic [SAMPLE_BITS-1:0] out_re_r, out_im_r;
  logic [SAMPLE_BITS-1:0] re_nxt, im_nxt;
  cordic_t     chain [0:NUM_CELLS];

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_slope_r   <= '0;
      position_step_r <= 32'd1;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_PHASE_SLOPE:   phase_slope_r   <= cfg_data;
        REG_POSITION_STEP: position_step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  qpr_phase u_phase (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .in_acc         (in_acc),
    .in_re          ($signed(in_tdata[15:0])),
    .in_im          ($signed(in_tdata[31:16])),
    .record_start   (in_tuser[0]),
    .start_position (in_tdata[63:32]),
    .phase_slope    (phase_slope_r),
    .position_step  (position_step_r),
    .cell_o         (chain[0])
  );

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    qpr_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .idx    (5'(g)),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  function automatic logic [SAMPLE_BITS-1:0] finish(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    r = (v + XW'(1 << (GAIN_FRAC-1))) >>> GAIN_FRAC;
    if (r > XW'(SMAX))      return SMAX;
    else if (r < XW'(SMIN)) return SMIN;
    else                    return r[SAMPLE_BITS-1:0];
  endfunction

  assign re_nxt = finish(chain[NUM_CELLS].x);
  assign im_nxt = finish(chain[NUM_CELLS].y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= chain[NUM_CELLS].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_re_r <= re_nxt;
      out_im_r <= im_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_im_r, out_re_r};

  a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while output stalled");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("held result changed under stall");

  a_chain_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(chain[0].vld) && $stable(chain[NUM_CELLS].vld))
    else $error("chain moved while frozen");

endmodule
`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quadratic phase rotator: directed table, then
// random records under bursty input and stalled output, against a predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb;
  import qpr_pkg::*;

  typedef struct packed {
    logic signed [15:0] im;
    logic signed [15:0] re;
  } iq_t;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               rs;
    logic [31:0]        sp;
    logic               has_exp;
    iq_t                exp_iq;
  } row_t;

  localparam int LATENCY = 21;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [63:0]       in_tdata = '0;
  logic [0:0]        in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [31:0]       out_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [31:0]       cfg_data = '0;

  logic [31:0] slope_q;
  logic [31:0] step_q;
  logic [31:0] pos_q;
  iq_t         rotated_q[$];
  int          errors = 0;
  bit          hold_off = 1'b0;
  bit          stall_on = 1'b1;

  quadratic_phase_rotator_top u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [63:0] fshift(logic signed [63:0] v, int n);
    return v >>> n;
  endfunction

  function automatic logic [15:0] round_sat(logic signed [63:0] v);
    logic signed [63:0] r;
    r = fshift(v + 64'sd524288, GAIN_FRAC);
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < -64'sd32768) r = -64'sd32768;
    return r[15:0];
  endfunction

  function automatic iq_t rotate_sample(logic signed [15:0] re, logic signed [15:0] im,
                                        logic rs, logic [31:0] sp);
    logic [31:0]        t;
    logic [63:0]        prod;
    logic [31:0]        zu;
    logic signed [63:0] x, y, z, dx, dy;
    iq_t                r;
    t = rs ? sp : pos_q;
    pos_q = t + step_q;
    prod = {{32{slope_q[31]}}, slope_q} * ({32'd0, t} * {32'd0, t});
    zu = 32'd0 - {prod[63:64-PHASE_BITS], {(32-PHASE_BITS){1'b0}}};
    z = $signed({{32{zu[31]}}, zu});
    x = 64'(re) * 64'sd636751;
    y = 64'(im) * 64'sd636751;
    if (z > 64'sd1073741824) begin
      x = -x; y = -y; z = z - 64'sd2147483648;
    end else if (z < -64'sd1073741824) begin
      x = -x; y = -y; z = z + 64'sd2147483648;
    end
    for (int i = 0; i < NUM_CELLS; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - $signed({32'd0, atan_turns(i[4:0])});
      end else begin
        x = x + dx; y = y - dy; z = z + $signed({32'd0, atan_turns(i[4:0])});
      end
    end
    r.re = round_sat(x);
    r.im = round_sat(y);
    return r;
  endfunction

  // leaves valid high; caller lowers it after the last write
  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_PHASE_SLOPE) slope_q = val;
    else step_q = val;
  endtask

  task automatic drain();
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // holds valid high across back-to-back requests; caller lowers it
  task automatic send(logic signed [15:0] re, logic signed [15:0] im, logic rs,
                      logic [31:0] sp);
    in_tvalid <= 1'b1;
    in_tdata  <= {sp, im, re};
    in_tuser  <= rs;
    do @(posedge clk); while (!in_tready);
    rotated_q.push_back(rotate_sample(re, im, rs, sp));
  endtask

  task automatic idle_gap();
    in_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  always @(posedge clk) begin
    iq_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (rotated_q.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        errors++;
      end else begin
        want = rotated_q.pop_front();
        if (got.re !== want.re) begin
          $error("out_re: expected %0d, got %0d", want.re, got.re);
          errors++;
        end
        if (got.im !== want.im) begin
          $error("out_im: expected %0d, got %0d", want.im, got.im);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls in stretches (none while stall_on is clear), plus a long hold-off on request
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      else if (!stall_on) out_tready <= 1'b1;
      else out_tready <= ((phase / 37) % 2 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    #20ms;
    $display("quadratic_phase_rotator_top: mismatch");
    $finish;
  end

  initial begin
    row_t        rows[$];
    row_t        rw;
    logic [31:0] slopes[6];
    logic [31:0] steps[6];
    int          burst, left;
    slope_q = 32'd0;
    step_q  = 32'd1;
    pos_q   = 32'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset the slope is zero: plain gain-compensated pass-through
    rows.push_back('{16'sd0, 16'sd0, 1'b0, 32'd0, 1'b1, '{re: 16'sd0, im: 16'sd0}});
    rows.push_back('{16'sd32767, 16'sd0, 1'b0, 32'd0, 1'b1,
                     '{re: 16'sd32767, im: -16'sd1}});
    rows.push_back('{-16'sd32768, -16'sd32768, 1'b1, 32'hFFFF_FFFF, 1'b0, '{0, 0}});
    rows.push_back('{16'sd32767, 16'sd32767, 1'b0, 32'h0, 1'b0, '{0, 0}});
    rows.push_back('{16'sd1000, -16'sd1000, 1'b1, 32'h5555_AAAA, 1'b0, '{0, 0}});
    foreach (rows[i]) begin
      rw = rows[i];
      send(rw.re, rw.im, rw.rs, rw.sp);
      if (rw.has_exp && rotated_q[$] !== rw.exp_iq) begin
        $error("directed row %0d: predictor disagrees with table", i);
        errors++;
      end
    end
    in_tvalid <= 1'b0;
    drain();

    slopes = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_4000, 32'hFFFF_FFFF, 32'd0, 32'h1234_5678};
    steps  = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'h0001_0000, 32'd1, 32'h0000_3001};
    for (int s = 0; s < 6; s++) begin
      write_reg(REG_PHASE_SLOPE, slopes[s]);
      write_reg(REG_POSITION_STEP, steps[s]);
      cfg_valid <= 1'b0;
      // directed corners under this setting: extremes, wrap, full scale
      send(16'sd32767, -16'sd32768, 1'b1, 32'hFFFF_FFFF);
      send(-16'sd32768, 16'sd32767, 1'b0, 32'd0);
      send(16'sd32767, 16'sd32767, 1'b1, 32'd0);
      send(-16'sd1, 16'sd1, 1'b0, 32'hFFFF_FFFF);
      if (s == 2) begin
        hold_off = 1'b1;
        for (int k = 0; k < 60; k++) send(16'($urandom), 16'($urandom), 1'b0, $urandom);
      end
      stall_on = (s % 3 != 1);
      left = 280;
      while (left > 0) begin
        burst = $urandom_range(1, 40);
        for (int k = 0; k < burst && left > 0; k++, left--)
          send(16'($urandom), 16'($urandom), ($urandom_range(0, 15) == 0), $urandom);
        if ($urandom_range(0, 2) == 0) begin
          in_tvalid <= 1'b0;
          while (rotated_q.size() != 0) @(posedge clk);
        end else begin
          idle_gap();
        end
      end
      in_tvalid <= 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("quadratic_phase_rotator_top: match");
    end else begin
      $display("quadratic_phase_rotator_top: mismatch");
    end
    $finish;
  end

endmodule
